// ===== src/hash_group_count_aggregator_assert.svh =====
// assertion macros for the hash group count aggregator
`ifndef HASH_GROUP_COUNT_AGGREGATOR_ASSERT_SVH
`define HASH_GROUP_COUNT_AGGREGATOR_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define HGCA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define HGCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/hgca_pkg.sv =====
// ----------------------------------------------------------------------------
// hgca_pkg
// shared types, constants and helpers of the hash group count aggregator
// ----------------------------------------------------------------------------
package hgca_pkg;

   localparam int KEY_FIELDS     = 4;
   localparam int KEY_W          = 32;
   localparam int ROT_AMOUNT     = 15;
   localparam int DEF_NUM_KEYS   = 4;
   localparam int DEF_MAX_GROUPS = 1024;
   localparam int DEF_BUCKETS    = 1024;

   localparam logic [1:0] REQ_CLEAR   = 2'd0;
   localparam logic [1:0] REQ_ADD     = 2'd1;
   localparam logic [1:0] REQ_FETCH   = 2'd2;
   localparam logic [1:0] REQ_IGNORED = 2'd3;

   localparam logic [2:0] ST_MERGED  = 3'd0;
   localparam logic [2:0] ST_NEW     = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_GROUP   = 3'd3;
   localparam logic [2:0] ST_END     = 3'd4;
   localparam logic [2:0] ST_CLEARED = 3'd5;

   // one classified command passed from front to back
   typedef struct packed {
      logic [1:0]                    kind;
      logic [KEY_FIELDS*KEY_W-1:0]   keys;
      logic [KEY_FIELDS-1:0]         kmask;
      logic [KEY_W-1:0]              cnt;
      logic [KEY_W-1:0]              hash;
   } cmd_type;

   function automatic logic [KEY_W-1:0] rotl15(input logic [KEY_W-1:0] h);
      return {h[KEY_W-ROT_AMOUNT-1:0], h[KEY_W-1:KEY_W-ROT_AMOUNT]};
   endfunction

endpackage

// ===== src/hash_group_count_aggregator.sv =====
// ----------------------------------------------------------------------------
// hash_group_count_aggregator
// hash group-by engine summing tuple counts per distinct key
// ----------------------------------------------------------------------------
// an add reads its bucket head, then walks the chain one entry at a time before it merges or inserts;
//   a fetch returns the next group in insertion order or the end status; a clear answers, then sweeps;
//   the back end takes a new command only back in idle; a two-deep command queue absorbs bursts
// reset: a clearing pass over all BUCKETS bucket heads runs after reset and
//   after every clear; requests queue but do not execute meanwhile
// results are registered and appear on rsp_valid in the cycle after execution; the receiver cannot stall
module hash_group_count_aggregator
   import hgca_pkg::*;
#(
   parameter int NUM_KEYS   = DEF_NUM_KEYS,
   parameter int MAX_GROUPS = DEF_MAX_GROUPS,
   parameter int BUCKETS    = DEF_BUCKETS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [KEY_W-1:0]  req_key_0,
   input  logic [KEY_W-1:0]  req_key_1,
   input  logic [KEY_W-1:0]  req_key_2,
   input  logic [KEY_W-1:0]  req_key_3,
   input  logic [KEY_W-1:0]  req_tuple_count,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [KEY_W-1:0]  rsp_group_key_0,
   output logic [KEY_W-1:0]  rsp_group_key_1,
   output logic [KEY_W-1:0]  rsp_group_key_2,
   output logic [KEY_W-1:0]  rsp_group_key_3,
   output logic [KEY_W-1:0]  rsp_group_count,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_data
);
   logic [2:0]  key_count_ff;
   logic        full, q_valid, q_pop, take, idle;
   cmd_type     q_cmd;
   logic [KEY_FIELDS*KEY_W-1:0] rkeys;

   // the register takes a write only while the engine is idle and its queue empty
   assign csr_ready = idle;
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         key_count_ff <= csr_data;
      end
   end

   // type three is dropped at the door: no result, no state change
   assign busy = full;
   assign take = start && !full && (req_type != REQ_IGNORED);

   hgca_front #(.NUM_KEYS(NUM_KEYS)) u_front (
      .clock, .reset, .take, .req_type,
      .keys({req_key_3, req_key_2, req_key_1, req_key_0}),
      .tuple_count(req_tuple_count), .key_count(key_count_ff),
      .full, .q_valid, .q_cmd, .q_pop);

   hgca_back #(.MAX_GROUPS(MAX_GROUPS), .BUCKETS(BUCKETS)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop, .idle,
      .rsp_valid, .rsp_status, .rsp_keys(rkeys), .rsp_count(rsp_group_count));

   assign rsp_group_key_0 = rkeys[0*KEY_W +: KEY_W];
   assign rsp_group_key_1 = rkeys[1*KEY_W +: KEY_W];
   assign rsp_group_key_2 = rkeys[2*KEY_W +: KEY_W];
   assign rsp_group_key_3 = rkeys[3*KEY_W +: KEY_W];
endmodule

// ===== src/hgca_ram.sv =====
// ----------------------------------------------------------------------------
// hgca_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
module hgca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== src/hgca_front.sv =====
// ----------------------------------------------------------------------------
// hgca_front
// takes requests, masks keys and folds the hash, feeds a two-entry queue
// ----------------------------------------------------------------------------
module hgca_front
   import hgca_pkg::*;
#(
   parameter int NUM_KEYS = DEF_NUM_KEYS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           take,
   input  logic [1:0]                     req_type,
   input  logic [KEY_FIELDS*KEY_W-1:0]    keys,
   input  logic [KEY_W-1:0]               tuple_count,
   input  logic [2:0]                     key_count,
   output logic                           full,
   output logic                           q_valid,
   output cmd_type                        q_cmd,
   input  logic                           q_pop
);
   localparam int LIM = (NUM_KEYS < KEY_FIELDS) ? NUM_KEYS : KEY_FIELDS;

   cmd_type    cmd;
   cmd_type    slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] n;
   logic [KEY_W-1:0] h;

   always_comb begin
      n = key_count;
      if (n == 3'd0) n = 3'd1;
      if (n > 3'(LIM)) n = 3'(LIM);
      h = '0;
      cmd.keys  = '0;
      cmd.kmask = '0;
      for (int i = 0; i < KEY_FIELDS; i++) begin
         if (3'(i) < n) begin
            h = rotl15(h) ^ keys[i*KEY_W +: KEY_W];
            cmd.keys[i*KEY_W +: KEY_W] = keys[i*KEY_W +: KEY_W];
            cmd.kmask[i] = 1'b1;
         end
      end
      cmd.kind = req_type;
      cmd.cnt  = tuple_count;
      cmd.hash = h;
   end

   assign full    = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd   = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ take;
      rp_in  = rp_ff ^ q_pop;
      cnt_in = cnt_ff + {1'b0, take} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (take) begin
         slot_ff[wp_ff] <= cmd;
      end
   end
endmodule

// ===== src/hgca_back.sv =====
// ----------------------------------------------------------------------------
// hgca_back
// executes commands: chain walk, merge, insert, fetch, clear sweep
// ----------------------------------------------------------------------------
module hgca_back
   import hgca_pkg::*;
#(
   parameter int MAX_GROUPS = DEF_MAX_GROUPS,
   parameter int BUCKETS    = DEF_BUCKETS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  cmd_type                     q_cmd,
   output logic                        q_pop,
   output logic                        idle,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [KEY_FIELDS*KEY_W-1:0] rsp_keys,
   output logic [KEY_W-1:0]            rsp_count
);
   `include "hash_group_count_aggregator_assert.svh"

   localparam int GW = $clog2(MAX_GROUPS);
   localparam int BW = $clog2(BUCKETS);
   localparam int LW = GW + 1;
   localparam int KW = KEY_FIELDS * KEY_W;

   typedef enum logic [7:0] {
      S_CLR   = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_HEAD  = 8'b00000100,
      S_LINK  = 8'b00001000,
      S_CMP   = 8'b00010000,
      S_FETCH = 8'b00100000,
      S_FOUT  = 8'b01000000,
      S_MERGE = 8'b10000000
   } state_type;

   state_type   st_ff, st_in;
   cmd_type     cur_ff, cur_in;
   logic [BW-1:0] sweep_ff, sweep_in;
   logic [LW-1:0] total_ff, total_in, rpos_ff, rpos_in, link_ff, link_in;
   logic [LW-1:0] head_ff, head_in;

   logic          h_we;   logic [BW-1:0] h_wa, h_ra; logic [LW-1:0] h_wd, h_rd;
   logic          g_we;   logic [GW-1:0] g_wa, g_ra;
   logic [KW-1:0] k_rd;   logic [KEY_W-1:0] s_wd, s_rd; logic [LW-1:0] l_rd;
   logic          s_we;   logic [GW-1:0] s_wa;

   logic       v_ff;
   logic [2:0] st_out_ff;
   logic [KW-1:0] k_out_ff;
   logic [KEY_W-1:0] c_out_ff;
   logic       emit;
   logic [2:0] e_st;
   logic [KW-1:0] e_k;
   logic [KEY_W-1:0] e_c;
   logic       key_hit;

   hgca_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
      .clock, .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd), .rd_addr(h_ra), .rd_data(h_rd));
   hgca_ram #(.WIDTH(KW), .DEPTH(MAX_GROUPS)) u_keys (
      .clock, .wr_en(g_we), .wr_addr(g_wa), .wr_data(cur_ff.keys), .rd_addr(g_ra),
      .rd_data(k_rd));
   hgca_ram #(.WIDTH(KEY_W), .DEPTH(MAX_GROUPS)) u_sums (
      .clock, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd), .rd_addr(g_ra), .rd_data(s_rd));
   hgca_ram #(.WIDTH(LW), .DEPTH(MAX_GROUPS)) u_links (
      .clock, .wr_en(g_we), .wr_addr(g_wa), .wr_data(head_ff), .rd_addr(g_ra),
      .rd_data(l_rd));

   logic [GW-1:0] cur_g;
   assign cur_g = GW'(link_ff - LW'(1));
   assign idle  = (st_ff == S_IDLE) && !q_valid;

   // only the key fields in use take part in the match
   always_comb begin
      key_hit = 1'b1;
      for (int i = 0; i < KEY_FIELDS; i++) begin
         if (cur_ff.kmask[i] && (k_rd[i*KEY_W +: KEY_W] != cur_ff.keys[i*KEY_W +: KEY_W]))
            key_hit = 1'b0;
      end
   end

   always_comb begin
      st_in = st_ff; cur_in = cur_ff; sweep_in = sweep_ff;
      total_in = total_ff; rpos_in = rpos_ff; link_in = link_ff; head_in = head_ff;
      h_we = 1'b0; h_wa = cur_ff.hash[BW-1:0]; h_wd = total_ff + LW'(1);
      h_ra = q_cmd.hash[BW-1:0];
      g_we = 1'b0; g_wa = total_ff[GW-1:0]; g_ra = cur_g;
      s_we = 1'b0; s_wa = total_ff[GW-1:0]; s_wd = cur_ff.cnt;
      q_pop = 1'b0; emit = 1'b0; e_st = ST_MERGED; e_k = '0; e_c = '0;
      case (st_ff)
         S_CLR: begin
            h_we = 1'b1; h_wa = sweep_ff; h_wd = '0;
            sweep_in = sweep_ff + BW'(1);
            if (sweep_ff == BW'(BUCKETS - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1; cur_in = q_cmd;
               case (q_cmd.kind)
                  REQ_CLEAR: begin
                     emit = 1'b1; e_st = ST_CLEARED;
                     total_in = '0; rpos_in = '0; sweep_in = '0; st_in = S_CLR;
                  end
                  REQ_ADD:   st_in = S_HEAD;
                  REQ_FETCH: begin
                     link_in = rpos_ff + LW'(1);
                     st_in = S_FETCH;
                  end
                  default: ;
               endcase
            end
         end
         S_HEAD: begin
            head_in = h_rd; link_in = h_rd; st_in = S_LINK;
         end
         S_LINK: begin
            // link_ff names the group to test; memory read issued via g_ra
            if (link_ff == '0 || link_ff > total_ff) begin
               emit = 1'b1; st_in = S_IDLE;
               if (total_ff == LW'(MAX_GROUPS)) begin
                  e_st = ST_FULL;
               end else begin
                  e_st = ST_NEW; g_we = 1'b1; s_we = 1'b1; h_we = 1'b1;
                  total_in = total_ff + LW'(1);
               end
            end else begin
               st_in = S_CMP;
            end
         end
         S_CMP: begin
            if (key_hit) begin
               st_in = S_MERGE;
            end else begin
               link_in = l_rd; st_in = S_LINK;
            end
         end
         S_MERGE: begin
            s_we = 1'b1; s_wa = cur_g; s_wd = s_rd + cur_ff.cnt;
            emit = 1'b1; e_st = ST_MERGED; st_in = S_IDLE;
         end
         S_FETCH: begin
            if (rpos_ff < total_ff) begin
               st_in = S_FOUT;
            end else begin
               emit = 1'b1; e_st = ST_END; st_in = S_IDLE;
            end
         end
         S_FOUT: begin
            emit = 1'b1; e_st = ST_GROUP; e_k = k_rd; e_c = s_rd;
            rpos_in = rpos_ff + LW'(1); st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR; sweep_ff <= '0; total_ff <= '0; rpos_ff <= '0; v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; sweep_ff <= sweep_in; total_ff <= total_in;
         rpos_ff <= rpos_in; v_ff <= emit;
      end
      cur_ff <= cur_in; link_ff <= link_in; head_ff <= head_in;
      st_out_ff <= e_st; k_out_ff <= e_k; c_out_ff <= e_c;
   end

   assign rsp_valid  = v_ff;
   assign rsp_status = st_out_ff;
   assign rsp_keys   = k_out_ff;
   assign rsp_count  = c_out_ff;

   `HGCA_ASSERT_IMPL(a_total_bound, clock, reset, 1'b1, total_ff <= LW'(MAX_GROUPS))
   `HGCA_ASSERT_IMPL(a_rpos_bound, clock, reset, 1'b1, rpos_ff <= total_ff)
   `HGCA_ASSERT_NEXT(a_clear_sweeps, clock, reset, st_ff == S_IDLE && q_pop && q_cmd.kind == REQ_CLEAR, st_ff == S_CLR)
endmodule

// ===== tb/sv/hgca_checker.sv =====
// ----------------------------------------------------------------------------
// hgca_checker
// watches the request, result and csr channels of the hash group count
// aggregator, keeps its own group table and compares every result
// ----------------------------------------------------------------------------
module hgca_checker
   import hgca_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic [1:0]       req_type,
   input  logic [KEY_W-1:0] req_key_0,
   input  logic [KEY_W-1:0] req_key_1,
   input  logic [KEY_W-1:0] req_key_2,
   input  logic [KEY_W-1:0] req_key_3,
   input  logic [KEY_W-1:0] req_tuple_count,
   input  logic             rsp_valid,
   input  logic [2:0]       rsp_status,
   input  logic [KEY_W-1:0] rsp_group_key_0,
   input  logic [KEY_W-1:0] rsp_group_key_1,
   input  logic [KEY_W-1:0] rsp_group_key_2,
   input  logic [KEY_W-1:0] rsp_group_key_3,
   input  logic [KEY_W-1:0] rsp_group_count,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_data,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GROUPS = DEF_MAX_GROUPS;
   localparam int NBKT   = DEF_BUCKETS;

   typedef struct {
      logic [2:0]       status;
      logic [KEY_W-1:0] keys [KEY_FIELDS];
      logic [KEY_W-1:0] cnt;
   } group_rsp_type;

   // heads and links hold group index + 1, zero for none
   int               heads [NBKT];
   logic [KEY_W-1:0] tbl_keys [GROUPS][KEY_FIELDS];
   logic [KEY_W-1:0] tbl_sums [GROUPS];
   int               tbl_links [GROUPS];
   int               total;
   int               rd_pos;
   logic [2:0]       key_count;
   group_rsp_type    awaited [$];

   function automatic group_rsp_type aggregate(input logic [1:0] kind,
                                               input logic [KEY_W-1:0] k [KEY_FIELDS],
                                               input logic [KEY_W-1:0] cnt);
      group_rsp_type    r;
      int               n;
      logic [KEY_W-1:0] h;
      int               b;
      int               link;
      int               g;
      bit               same;
      r.status = ST_END;
      r.cnt    = '0;
      foreach (r.keys[i]) r.keys[i] = '0;
      n = (key_count == 0) ? 1 : (key_count > KEY_FIELDS) ? KEY_FIELDS : key_count;
      case (kind)
         REQ_CLEAR: begin
            foreach (heads[i]) heads[i] = 0;
            total    = 0;
            rd_pos   = 0;
            r.status = ST_CLEARED;
         end
         REQ_FETCH: begin
            if (rd_pos < total) begin
               foreach (r.keys[i]) r.keys[i] = tbl_keys[rd_pos][i];
               r.cnt    = tbl_sums[rd_pos];
               r.status = ST_GROUP;
               rd_pos++;
            end else begin
               r.status = ST_END;
            end
         end
         default: begin
            h = '0;
            for (int i = 0; i < n; i++) h = {h[16:0], h[31:17]} ^ k[i];
            b    = h % NBKT;
            link = heads[b];
            while (link != 0 && link <= total) begin
               g    = link - 1;
               same = 1;
               for (int i = 0; i < n; i++)
                  if (tbl_keys[g][i] != k[i]) same = 0;
               if (same) begin
                  tbl_sums[g] = tbl_sums[g] + cnt;
                  r.status    = ST_MERGED;
                  return r;
               end
               link = tbl_links[g];
            end
            if (total >= GROUPS) begin
               r.status = ST_FULL;
               return r;
            end
            g = total;
            for (int i = 0; i < KEY_FIELDS; i++) tbl_keys[g][i] = (i < n) ? k[i] : '0;
            tbl_sums[g]  = cnt;
            tbl_links[g] = heads[b];
            heads[b]     = g + 1;
            total        = g + 1;
            r.status     = ST_NEW;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      logic [KEY_W-1:0] k [KEY_FIELDS];
      logic [KEY_W-1:0] got [KEY_FIELDS];
      group_rsp_type    e;
      if (reset) begin
         foreach (heads[i]) heads[i] = 0;
         total      = 0;
         rd_pos     = 0;
         key_count  = 3'd1;
         fail_count = 0;
         awaited.delete();
      end else begin
         if (csr_valid && csr_ready) key_count = csr_data;
         if (rsp_valid) begin
            if (awaited.size() == 0) begin
               $display("%0t unexpected result: status %0d", $time, rsp_status);
               fail_count++;
            end else begin
               e      = awaited.pop_front();
               got[0] = rsp_group_key_0;
               got[1] = rsp_group_key_1;
               got[2] = rsp_group_key_2;
               got[3] = rsp_group_key_3;
               if (rsp_status !== e.status) begin
                  $display("%0t status: expected %0d actual %0d", $time, e.status, rsp_status);
                  fail_count++;
               end
               foreach (got[i])
                  if (got[i] !== e.keys[i]) begin
                     $display("%0t group_key_%0d: expected %h actual %h",
                              $time, i, e.keys[i], got[i]);
                     fail_count++;
                  end
               if (rsp_group_count !== e.cnt) begin
                  $display("%0t group_count: expected %h actual %h",
                           $time, e.cnt, rsp_group_count);
                  fail_count++;
               end
            end
         end
         if (start && !busy && req_type != REQ_IGNORED) begin
            k[0] = req_key_0;
            k[1] = req_key_1;
            k[2] = req_key_2;
            k[3] = req_key_3;
            awaited.push_back(aggregate(req_type, k, req_tuple_count));
         end
      end
      pending = awaited.size();
   end

endmodule

// ===== tb/sv/tb_hash_group_count_aggregator.sv =====
// ----------------------------------------------------------------------------
// tb_hash_group_count_aggregator
// drives clear, add, fetch and ignored commands and csr writes into the aggregator;
// the checker beside it predicts and compares every result
// ----------------------------------------------------------------------------
module tb_hash_group_count_aggregator;
   import hgca_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [1:0]       req_type = REQ_CLEAR;
   logic [KEY_W-1:0] req_key_0 = '0, req_key_1 = '0, req_key_2 = '0, req_key_3 = '0;
   logic [KEY_W-1:0] req_tuple_count = '0;
   logic             rsp_valid;
   logic [2:0]       rsp_status;
   logic [KEY_W-1:0] rsp_group_key_0, rsp_group_key_1, rsp_group_key_2, rsp_group_key_3;
   logic [KEY_W-1:0] rsp_group_count;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_data = 3'd1;
   int               fail_count;
   int               pending;
   int               n_add, n_fetch, n_clear, n_other, n_csr;

   always #5 clock = ~clock;

   hash_group_count_aggregator u_top (.*);

   hgca_checker u_checker (.*);

   // generous fixed limit: clearing passes plus worst chain walks
   initial begin
      #200000000;
      $display("tb: failure");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // keys from a small pool give merges, the rest spread out
   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 7);
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // one transaction on the command channel; start stays high over a zero gap
   task automatic send(input logic [1:0] kind, input logic [KEY_W-1:0] k0,
                       input logic [KEY_W-1:0] k1, input logic [KEY_W-1:0] k2,
                       input logic [KEY_W-1:0] k3, input logic [KEY_W-1:0] cnt,
                       input int gap);
      start           <= 1'b1;
      req_type        <= kind;
      req_key_0       <= k0;
      req_key_1       <= k1;
      req_key_2       <= k2;
      req_key_3       <= k3;
      req_tuple_count <= cnt;
      @(posedge clock);
      while (busy) @(posedge clock);
      case (kind)
         REQ_CLEAR: n_clear++;
         REQ_ADD:   n_add++;
         REQ_FETCH: n_fetch++;
         default:   n_other++;
      endcase
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for the table to settle, then write key_count
   task automatic write_key_count(input logic [2:0] v);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      n_csr++;
   endtask

   task automatic random_burst(input int items);
      int r;
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55)
            send(REQ_ADD, pick_key(), pick_key(), pick_key(), pick_key(),
                 ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom, pick_gap());
         else if (r < 92)
            send(REQ_FETCH, $urandom, $urandom, $urandom, $urandom, $urandom, pick_gap());
         else if (r < 95)
            send(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, pick_gap());
         else
            send(REQ_IGNORED, $urandom, $urandom, $urandom, $urandom, $urandom, pick_gap());
      end
   endtask

   initial begin
      logic [2:0] settings [7];
      settings = '{3'd0, 3'd4, 3'd2, 3'd7, 3'd3, 3'd1, 3'd5};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fetch on an empty table, wrap of the sum, unused keys zeroed
      send(REQ_FETCH, '0, '0, '0, '0, '0, 0);
      send(REQ_ADD, 32'hFFFF_FFFF, 32'h1234_5678, '1, '1, 32'hFFFF_FFFF, 0);
      send(REQ_ADD, 32'hFFFF_FFFF, 32'h0, '0, '0, 32'hFFFF_FFFF, 1);
      send(REQ_ADD, 32'h0, '1, '1, '1, 32'h0, 0);
      send(REQ_IGNORED, '1, '1, '1, '1, '1, 2);
      send(REQ_FETCH, '0, '0, '0, '0, '0, 0);
      send(REQ_FETCH, '0, '0, '0, '0, '0, 0);
      send(REQ_FETCH, '0, '0, '0, '0, '0, 0);
      send(REQ_ADD, 32'h5, '0, '0, '0, 32'h7, 0);   // add between fetches
      send(REQ_FETCH, '0, '0, '0, '0, '0, 0);
      send(REQ_FETCH, '0, '0, '0, '0, '0, 0);
      send(REQ_FETCH, '0, '0, '0, '0, '0, 0);       // end keeps repeating

      // pause until all results are in
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      // fill the store: distinct keys, then drops and a merge while full
      send(REQ_CLEAR, '0, '0, '0, '0, '0, 0);
      for (int i = 0; i < 1030; i++)
         send(REQ_ADD, i, $urandom, $urandom, $urandom, $urandom, pick_gap());
      send(REQ_ADD, 32'd17, '0, '0, '0, 32'd1, 0);
      for (int i = 0; i < 12; i++)
         send(REQ_FETCH, '0, '0, '0, '0, '0, pick_gap());
      send(REQ_CLEAR, '0, '0, '0, '0, '0, 0);

      // random phases across key_count settings, out-of-range ones included
      foreach (settings[s]) begin
         write_key_count(settings[s]);
         send(REQ_CLEAR, '0, '0, '0, '0, '0, 0);
         random_burst(110);
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("covered %0d adds, %0d fetches, %0d clears, %0d ignored commands",
               n_add, n_fetch, n_clear, n_other);
      $display("with %0d key_count writes, a full store and sum wrap-around", n_csr);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
